// ===== design/pmq_pkg.sv =====
// Shared constants, codes and types of the presence mailbox queue.
`default_nettype none
package pmq_pkg;

    localparam int USER_SLOTS    = 16;
    localparam int PENDING_DEPTH = 32;

    localparam int ID_W    = 16;
    localparam int MSG_W   = 16;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 3;
    localparam int SLOT_AW = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
    localparam int SLOT_CW = $clog2(USER_SLOTS + 1);
    localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(PENDING_DEPTH + 1);
    localparam int STORE_AW = SLOT_AW + PEND_AW;

    localparam logic [OP_W-1:0] OP_NOTIFY = 2'd0;
    localparam logic [OP_W-1:0] OP_LOGIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOGOUT = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [KIND_W-1:0] KIND_LIVE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUEUED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOGIN   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PENDING = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOSLOT  = 3'd5;

    // Per-user presence record
    typedef struct packed {
        logic             online;
        logic [CNT_W-1:0] count;
    } t_slot_state;

    // Result of an id search
    typedef struct packed {
        logic               hit;
        logic [SLOT_AW-1:0] idx;
    } t_lookup;

endpackage
`default_nettype wire

// ===== design/presence_mailbox_queue_unit.sv =====
// Top level of the presence mailbox queue: request sequencer and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: op, user_id,
//   sender id, msg_handle. Op notify delivers live to an online user, queues the
//   handle for an offline user, or reports queue full. Op login reports the login
//   and then flushes the user's pending handles in arrival order. Op logout gives
//   no result. Unknown ids get a new slot on notify or login; a full table
//   reports no slot.
//   Output channel (o_out_valid / i_out_stall) carries results; o_last marks the
//   final result of a request.
// Sequence:
//   After acceptance a request passes a wait state after the id compare, then the
//   id encode and record read, then execute, which loads its first result; a no-slot
//   report is loaded at the encode step. A login with pending handles fetches each
//   one by a registered read of the pending store, then outputs it. One request is
//   processed at a time; the next one is taken as soon as the final result sits in
//   the output register.
// Reset: synchronous, active low; clears the slot count and all presence records.
// Stall: a stalled result holds in the output register and the sequencer waits.
`default_nettype none
module presence_mailbox_queue_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [pmq_pkg::OP_W-1:0]      i_op,
    input  wire logic [pmq_pkg::ID_W-1:0]      i_user_id,
    input  wire logic [pmq_pkg::ID_W-1:0]      i_src_user,
    input  wire logic [pmq_pkg::MSG_W-1:0]     i_msg_handle,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [pmq_pkg::KIND_W-1:0]         o_kind,
    output logic [pmq_pkg::ID_W-1:0]           o_target_user,
    output logic [pmq_pkg::ID_W-1:0]           o_sender,
    output logic [pmq_pkg::MSG_W-1:0]          o_message,
    output logic                               o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_FIND,
        S_EXEC,
        S_FL_RD,
        S_FL_OUT
    } t_state;

    t_state                         r_state;
    logic [pmq_pkg::OP_W-1:0]       r_op;
    logic [pmq_pkg::ID_W-1:0]       r_uid;
    logic [pmq_pkg::ID_W-1:0]       r_from;
    logic [pmq_pkg::MSG_W-1:0]      r_msg;
    logic [pmq_pkg::SLOT_AW-1:0]    r_slot;
    logic                           r_fresh;
    logic [pmq_pkg::CNT_W-1:0]      r_idx;
    logic [pmq_pkg::CNT_W-1:0]      r_cnt;

    logic                           r_out_valid;
    logic [pmq_pkg::KIND_W-1:0]     r_kind;
    logic [pmq_pkg::ID_W-1:0]       r_target;
    logic [pmq_pkg::ID_W-1:0]       r_sender;
    logic [pmq_pkg::MSG_W-1:0]      r_message;
    logic                           r_last;

    pmq_pkg::t_lookup               w_lookup;
    logic [pmq_pkg::SLOT_CW-1:0]    w_used;
    logic                           w_full;
    logic                           w_out_free;
    logic                           w_accept;
    logic                           w_is_alloc_op;
    pmq_pkg::t_slot_state           w_rec_rd;
    pmq_pkg::t_slot_state           w_rec;
    logic [pmq_pkg::MSG_W-1:0]      w_pend_rd;
    logic                           w_has_room;
    logic                           w_fl_last;
    logic                           w_emit;

    // Memory and table controls
    logic                           w_cmp_en;
    logic                           w_alloc;
    logic                           w_st_wr_en;
    logic [pmq_pkg::SLOT_AW-1:0]    w_st_wr_addr;
    pmq_pkg::t_slot_state           w_st_wr_data;
    logic                           w_st_rd_en;
    logic                           w_pd_wr_en;
    logic                           w_pd_rd_en;

    assign w_accept      = i_in_valid && (r_state == S_IDLE);
    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_full        = (w_used == pmq_pkg::SLOT_CW'(pmq_pkg::USER_SLOTS));
    assign w_is_alloc_op = (r_op == pmq_pkg::OP_NOTIFY) || (r_op == pmq_pkg::OP_LOGIN);
    // A newly allocated slot starts offline with an empty queue.
    assign w_rec         = r_fresh ? '0 : w_rec_rd;
    assign w_has_room    = (w_rec.count < pmq_pkg::CNT_W'(pmq_pkg::PENDING_DEPTH));
    assign w_fl_last     = ((r_idx + pmq_pkg::CNT_W'(1)) == r_cnt);
    // Load a new result into the output register this cycle.
    assign w_emit        = w_out_free &&
                           (((r_state == S_FIND) && !w_lookup.hit && w_is_alloc_op && w_full) ||
                            ((r_state == S_EXEC) && (r_op != pmq_pkg::OP_LOGOUT)) ||
                            (r_state == S_FL_OUT));

    always_comb begin
        w_cmp_en     = w_accept;
        w_alloc      = 1'b0;
        w_st_wr_en   = 1'b0;
        w_st_wr_addr = r_slot;
        w_st_wr_data = '0;
        w_st_rd_en   = 1'b0;
        w_pd_wr_en   = 1'b0;
        w_pd_rd_en   = 1'b0;
        unique case (r_state)
            S_FIND: begin
                if (w_lookup.hit) begin
                    w_st_rd_en = 1'b1;
                end else if (w_is_alloc_op && !w_full) begin
                    // Allocate the next slot and clear its record.
                    w_alloc      = 1'b1;
                    w_st_wr_en   = 1'b1;
                    w_st_wr_addr = w_used[pmq_pkg::SLOT_AW-1:0];
                end
            end
            S_EXEC: begin
                priority if (r_op == pmq_pkg::OP_LOGOUT) begin
                    w_st_wr_en          = 1'b1;
                    w_st_wr_data.online = 1'b0;
                    w_st_wr_data.count  = w_rec.count;
                end else if (w_out_free && r_op == pmq_pkg::OP_LOGIN) begin
                    w_st_wr_en          = 1'b1;
                    w_st_wr_data.online = 1'b1;
                end else if (w_out_free && !w_rec.online && w_has_room) begin
                    // Queue the handle behind those already waiting.
                    w_pd_wr_en          = 1'b1;
                    w_st_wr_en          = 1'b1;
                    w_st_wr_data.count  = w_rec.count + pmq_pkg::CNT_W'(1);
                end else begin
                end
            end
            S_FL_RD: begin
                w_pd_rd_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    pmq_id_cam u_cam (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmp_en   (w_cmp_en),
        .i_cmp_id   (i_user_id),
        .i_alloc    (w_alloc),
        .i_alloc_id (r_uid),
        .o_lookup   (w_lookup),
        .o_used     (w_used)
    );

    pmq_state_mem u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_st_wr_en),
        .i_wr_addr (w_st_wr_addr),
        .i_wr_data (w_st_wr_data),
        .i_rd_en   (w_st_rd_en),
        .i_rd_addr (w_lookup.idx),
        .o_rd_data (w_rec_rd)
    );

    pmq_pend_mem u_pend (
        .i_clk     (i_clk),
        .i_wr_en   (w_pd_wr_en),
        .i_wr_addr ({r_slot, w_rec.count[pmq_pkg::PEND_AW-1:0]}),
        .i_wr_data (r_msg),
        .i_rd_en   (w_pd_rd_en),
        .i_rd_addr ({r_slot, r_idx[pmq_pkg::PEND_AW-1:0]}),
        .o_rd_data (w_pend_rd)
    );

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Hold a stalled result, drop a taken one, raise on a new one.
            r_out_valid <= w_emit || (r_out_valid && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= i_op;
                        r_uid  <= i_user_id;
                        r_from <= i_src_user;
                        r_msg  <= i_msg_handle;
                        // Drop the unused op code outright.
                        if (i_op != pmq_pkg::OP_UNUSED) begin
                            r_state <= S_MATCH;
                        end
                    end
                end
                S_MATCH: begin
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    r_fresh <= 1'b0;
                    r_slot  <= w_lookup.idx;
                    if (w_lookup.hit) begin
                        r_state <= S_EXEC;
                    end else if (!w_is_alloc_op) begin
                        r_state <= S_IDLE;
                    end else if (!w_full) begin
                        r_fresh <= 1'b1;
                        r_slot  <= w_used[pmq_pkg::SLOT_AW-1:0];
                        r_state <= S_EXEC;
                    end else if (w_out_free) begin
                        r_kind      <= pmq_pkg::KIND_NOSLOT;
                        r_target    <= r_uid;
                        r_sender    <= '0;
                        r_message   <= '0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_EXEC: begin
                    if (r_op == pmq_pkg::OP_LOGOUT) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_target    <= r_uid;
                        r_sender    <= '0;
                        r_message   <= '0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_op == pmq_pkg::OP_LOGIN) begin
                            r_kind <= pmq_pkg::KIND_LOGIN;
                            r_idx  <= '0;
                            r_cnt  <= w_rec.count;
                            if (w_rec.count != '0) begin
                                r_last  <= 1'b0;
                                r_state <= S_FL_RD;
                            end
                        end else if (w_rec.online) begin
                            r_kind    <= pmq_pkg::KIND_LIVE;
                            r_sender  <= r_from;
                            r_message <= r_msg;
                        end else if (w_has_room) begin
                            r_kind    <= pmq_pkg::KIND_QUEUED;
                            r_message <= r_msg;
                        end else begin
                            r_kind <= pmq_pkg::KIND_FULL;
                        end
                    end
                end
                S_FL_RD: begin
                    r_state <= S_FL_OUT;
                end
                S_FL_OUT: begin
                    // Hold the fetched handle until the result register frees up.
                    if (w_out_free) begin
                        r_kind      <= pmq_pkg::KIND_PENDING;
                        r_target    <= r_uid;
                        r_sender    <= '0;
                        r_message   <= w_pend_rd;
                        r_last      <= w_fl_last;
                        r_idx       <= r_idx + pmq_pkg::CNT_W'(1);
                        r_state     <= w_fl_last ? S_IDLE : S_FL_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_target_user = r_target;
    assign o_sender      = r_sender;
    assign o_message     = r_message;
    assign o_last        = r_last;

endmodule
`default_nettype wire

// ===== design/pmq_id_cam.sv =====
// Id table: slot ids, allocation count and registered id search.
`default_nettype none
module pmq_id_cam (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmp_en,
    input  wire logic [pmq_pkg::ID_W-1:0]      i_cmp_id,
    input  wire logic                          i_alloc,
    input  wire logic [pmq_pkg::ID_W-1:0]      i_alloc_id,
    output pmq_pkg::t_lookup                   o_lookup,
    output logic [pmq_pkg::SLOT_CW-1:0]        o_used
);

    logic [pmq_pkg::ID_W-1:0]       r_ids [pmq_pkg::USER_SLOTS];
    logic [pmq_pkg::USER_SLOTS-1:0] r_match;
    logic [pmq_pkg::SLOT_CW-1:0]    r_used;

    // Compare every live slot at once, register the hit vector.
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            for (int i = 0; i < pmq_pkg::USER_SLOTS; i++) begin
                r_match[i] <= (pmq_pkg::SLOT_CW'(i) < r_used) && (r_ids[i] == i_cmp_id);
            end
        end
        if (i_alloc) begin
            r_ids[r_used[pmq_pkg::SLOT_AW-1:0]] <= i_alloc_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_alloc) begin
            r_used <= r_used + pmq_pkg::SLOT_CW'(1);
        end
    end

    // Lowest matching slot wins.
    always_comb begin
        o_lookup = '0;
        for (int i = pmq_pkg::USER_SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                o_lookup.hit = 1'b1;
                o_lookup.idx = pmq_pkg::SLOT_AW'(i);
            end
        end
    end

    assign o_used = r_used;

endmodule
`default_nettype wire

// ===== design/pmq_state_mem.sv =====
// Presence record memory with per-entry valid bits; unwritten entries read as zero.
`default_nettype none
module pmq_state_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [pmq_pkg::SLOT_AW-1:0]   i_wr_addr,
    input  wire pmq_pkg::t_slot_state          i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [pmq_pkg::SLOT_AW-1:0]   i_rd_addr,
    output pmq_pkg::t_slot_state               o_rd_data
);

    pmq_pkg::t_slot_state           r_mem [pmq_pkg::USER_SLOTS];
    logic [pmq_pkg::USER_SLOTS-1:0] r_valid;
    pmq_pkg::t_slot_state           r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== design/pmq_pend_mem.sv =====
// Pending message store: one queue region per slot, registered read.
`default_nettype none
module pmq_pend_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [pmq_pkg::STORE_AW-1:0]  i_wr_addr,
    input  wire logic [pmq_pkg::MSG_W-1:0]     i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [pmq_pkg::STORE_AW-1:0]  i_rd_addr,
    output logic [pmq_pkg::MSG_W-1:0]          o_rd_data
);

    logic [pmq_pkg::MSG_W-1:0] r_mem [2**pmq_pkg::STORE_AW];
    logic [pmq_pkg::MSG_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the presence mailbox queue: directed and random requests.
`default_nettype none
module testbench;
    import pmq_pkg::*;

    // Stimulus stops once this many requests that the block acts on were sent
    localparam int ITEM_TARGET  = 270;
    // Window of sent requests in which neither side idles
    localparam int QUIET_FROM   = 150;
    localparam int QUIET_TO     = 210;
    // A logout or an unused op may still be in flight when the last result lands
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   target_user;
        logic [ID_W-1:0]   sender;
        logic [MSG_W-1:0]  message;
        logic              last;
    } mail_result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [OP_W-1:0]   in_op     = OP_UNUSED;
    logic [ID_W-1:0]   in_user   = '0;
    logic [ID_W-1:0]   in_from   = '0;
    logic [MSG_W-1:0]  in_msg    = '0;
    logic              out_stall = 1'b0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [KIND_W-1:0] o_kind;
    logic [ID_W-1:0]   o_target_user;
    logic [ID_W-1:0]   o_sender;
    logic [MSG_W-1:0]  o_message;
    logic              o_last;

    // Idle enables: the sender reads in_idle_en itself, the stall process reads out_idle_en
    bit                in_idle_en  = 1'b1;
    logic              out_idle_en = 1'b1;

    int                sent_items = 0;
    int                fail_count = 0;

    // Results still owed by the block, oldest first
    mail_result_t      due_results[$];

    // Shadow of the presence table: ids, online flags, queue fill and queued handles
    logic [ID_W-1:0]   table_id     [USER_SLOTS];
    logic              table_online [USER_SLOTS];
    int                table_count  [USER_SLOTS];
    logic [MSG_W-1:0]  mailbox      [USER_SLOTS][PENDING_DEPTH];
    int                table_fill = 0;

    // Ids that the random traffic mostly talks to; enough of them to fill the table
    logic [ID_W-1:0]   user_pool [USER_SLOTS] = '{default: '0};
    logic [OP_W-1:0]   op_menu [4] = '{OP_NOTIFY, OP_LOGIN, OP_LOGOUT, OP_UNUSED};

    presence_mailbox_queue_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (in_op),
        .i_user_id     (in_user),
        .i_src_user    (in_from),
        .i_msg_handle  (in_msg),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (o_kind),
        .o_target_user (o_target_user),
        .o_sender      (o_sender),
        .o_message     (o_message),
        .o_last        (o_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random while idling is enabled
    always @(posedge clk) begin
        out_stall <= out_idle_en && ($urandom_range(99) < 13);
    end

    function automatic logic [ID_W-1:0] any_word();
        return ID_W'($urandom_range(65535));
    endfunction

    function automatic int shadow_slot(input logic [ID_W-1:0] uid);
        for (int i = 0; i < table_fill; i++)
            if (table_id[i] == uid)
                return i;
        return -1;
    endfunction

    function automatic bit in_pool(input logic [ID_W-1:0] uid);
        foreach (user_pool[i])
            if (user_pool[i] == uid)
                return 1'b1;
        return 1'b0;
    endfunction

    // Pick an id that is neither in the pool nor holding a slot
    function automatic logic [ID_W-1:0] pick_stranger();
        logic [ID_W-1:0] id;
        do
            id = any_word();
        while (in_pool(id) || shadow_slot(id) >= 0);
        return id;
    endfunction

    task automatic owe_result(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] uid,
                              input logic [ID_W-1:0] snd, input logic [MSG_W-1:0] msg,
                              input logic last);
        mail_result_t r;
        r.kind        = kind;
        r.target_user = uid;
        r.sender      = snd;
        r.message     = msg;
        r.last        = last;
        due_results.push_back(r);
    endtask

    // Advance the shadow table by one accepted request and record the results it owes
    task automatic model_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] uid,
                                 input logic [ID_W-1:0] from, input logic [MSG_W-1:0] msg);
        int s;
        int n;
        s = shadow_slot(uid);
        case (op)
            OP_NOTIFY, OP_LOGIN: begin
                // First contact takes the next free slot, offline with an empty queue
                if (s < 0 && table_fill < USER_SLOTS) begin
                    s = table_fill;
                    table_fill++;
                    table_id[s]     = uid;
                    table_online[s] = 1'b0;
                    table_count[s]  = 0;
                end
                if (s < 0) begin
                    owe_result(KIND_NOSLOT, uid, '0, '0, 1'b1);
                end else if (op == OP_NOTIFY) begin
                    if (table_online[s]) begin
                        owe_result(KIND_LIVE, uid, from, msg, 1'b1);
                    end else if (table_count[s] < PENDING_DEPTH) begin
                        mailbox[s][table_count[s]] = msg;
                        table_count[s]++;
                        owe_result(KIND_QUEUED, uid, '0, msg, 1'b1);
                    end else begin
                        owe_result(KIND_FULL, uid, '0, '0, 1'b1);
                    end
                end else begin
                    // Login report, then the backlog in arrival order
                    n = table_count[s];
                    owe_result(KIND_LOGIN, uid, '0, '0, n == 0);
                    for (int i = 0; i < n; i++)
                        owe_result(KIND_PENDING, uid, '0, mailbox[s][i], i == n - 1);
                    table_online[s] = 1'b1;
                    table_count[s]  = 0;
                end
            end
            OP_LOGOUT: begin
                if (s >= 0)
                    table_online[s] = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Offer one request, hold it until accepted, then model it
    task automatic post_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] uid,
                                input logic [ID_W-1:0] from, input logic [MSG_W-1:0] msg);
        bit quiet;
        while (in_idle_en && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_user  <= uid;
        in_from  <= from;
        in_msg   <= msg;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        model_request(op, uid, from, msg);
        if (op != OP_UNUSED)
            sent_items++;
        // Drop idling on both sides for a stretch in the middle of the run
        quiet       = sent_items >= QUIET_FROM && sent_items < QUIET_TO;
        in_idle_en  = !quiet;
        out_idle_en <= !quiet;
    endtask

    // Compare every accepted result with the oldest owed one
    always @(posedge clk) begin : check_results
        mail_result_t due;
        if (rst_n && o_out_valid && !out_stall) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d user %h", o_kind, o_target_user);
                fail_count++;
            end else begin
                due = due_results.pop_front();
                if (o_kind !== due.kind) begin
                    $error("kind: expected %0d, got %0d", due.kind, o_kind);
                    fail_count++;
                end
                if (o_target_user !== due.target_user) begin
                    $error("target_user: expected %h, got %h", due.target_user, o_target_user);
                    fail_count++;
                end
                if (o_sender !== due.sender) begin
                    $error("sender: expected %h, got %h", due.sender, o_sender);
                    fail_count++;
                end
                if (o_message !== due.message) begin
                    $error("message: expected %h, got %h", due.message, o_message);
                    fail_count++;
                end
                if (o_last !== due.last) begin
                    $error("last: expected %0d, got %0d", due.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // Field extremes, live and queued delivery, login flush, logout, ignored requests
    task automatic test_presence_basics();
        logic [ID_W-1:0] stranger;
        post_request(OP_NOTIFY, user_pool[0], 16'hFFFF, 16'hFFFF);
        post_request(OP_NOTIFY, user_pool[0], 16'h0000, 16'h0000);
        post_request(OP_LOGIN,  user_pool[0], 16'hFFFF, 16'hFFFF);
        post_request(OP_NOTIFY, user_pool[0], 16'hFFFF, 16'hFFFF);
        post_request(OP_NOTIFY, user_pool[0], 16'h0000, 16'h0000);
        // Login of a user already online: report only
        post_request(OP_LOGIN,  user_pool[0], 16'h0000, 16'h0000);
        post_request(OP_LOGOUT, user_pool[0], any_word(), any_word());
        post_request(OP_NOTIFY, user_pool[0], any_word(), any_word());
        // Logout of an unknown id takes no slot
        stranger = pick_stranger();
        post_request(OP_LOGOUT, stranger, any_word(), any_word());
        post_request(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // First contact by login
        post_request(OP_LOGIN,  user_pool[1], 16'h0000, 16'h0000);
        post_request(OP_LOGOUT, user_pool[1], any_word(), any_word());
        post_request(OP_NOTIFY, user_pool[1], any_word(), any_word());
    endtask

    // Fill one offline queue past its depth, then flush the longest backlog
    task automatic test_queue_overflow();
        repeat (PENDING_DEPTH + 1)
            post_request(OP_NOTIFY, user_pool[2], any_word(), any_word());
        post_request(OP_LOGIN,  user_pool[2], any_word(), any_word());
        post_request(OP_LOGOUT, user_pool[2], any_word(), any_word());
    endtask

    // Claim every slot, then address ids that find no room
    task automatic test_table_full();
        logic [ID_W-1:0] stranger;
        for (int i = 0; i < USER_SLOTS; i++)
            post_request((i % 2) ? OP_LOGIN : OP_NOTIFY, user_pool[i], any_word(), any_word());
        stranger = pick_stranger();
        post_request(OP_NOTIFY, stranger, any_word(), any_word());
        post_request(OP_LOGIN,  stranger, any_word(), any_word());
        post_request(OP_LOGOUT, stranger, any_word(), any_word());
    endtask

    // Mostly offline sessions with random content, the rest scattered noise
    task automatic test_random_traffic();
        logic [ID_W-1:0] uid;
        int burst;
        while (sent_items < ITEM_TARGET) begin
            if ($urandom_range(99) < 65) begin
                // Log out, collect a burst, log back in, then chat live a little
                uid   = user_pool[$urandom_range(USER_SLOTS - 1)];
                burst = ($urandom_range(99) < 20) ? $urandom_range(36, 28)
                                                  : $urandom_range(8, 1);
                post_request(OP_LOGOUT, uid, any_word(), any_word());
                repeat (burst)
                    post_request(OP_NOTIFY, uid, any_word(), any_word());
                post_request(OP_LOGIN, uid, any_word(), any_word());
                repeat ($urandom_range(3))
                    post_request(OP_NOTIFY, uid, any_word(), any_word());
            end else begin
                uid = ($urandom_range(99) < 85) ? user_pool[$urandom_range(USER_SLOTS - 1)]
                                                : any_word();
                post_request(op_menu[$urandom_range(3)], uid, any_word(), any_word());
            end
        end
    endtask

    initial begin
        logic [ID_W-1:0] cand;
        // Pool holds both id extremes plus distinct random ids
        user_pool[1] = 16'hFFFF;
        for (int i = 2; i < USER_SLOTS; i++) begin
            do
                cand = any_word();
            while (in_pool(cand));
            user_pool[i] = cand;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_presence_basics();
        test_queue_overflow();
        test_table_full();
        test_random_traffic();

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/pmq_pkg.sv
design/pmq_id_cam.sv
design/pmq_state_mem.sv
design/pmq_pend_mem.sv
design/presence_mailbox_queue_unit.sv
tb/testbench.sv
